// File: rtl/core/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared types, character codes and small decode functions.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_SUM1,
    PH_SUM2
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  localparam logic [3:0] NOT_DIGIT   = 4'd15;
  localparam logic [2:0] HDR_LEN     = 3'd5;
  localparam logic [2:0] CAPTURE_LEN = 3'd6;
  localparam logic [2:0] POS_MAX     = 3'd7;
  localparam logic [3:0] FIELD_MAX   = 4'd15;
  localparam logic [3:0] FIELD_TIME  = 4'd1;
  localparam logic [3:0] FIELD_DATE  = 4'd9;

  // Six held values: hour, minute, second, day, month, year
  typedef logic [5:0][6:0] td_vec_t;

  // Digit store control from the parser
  typedef struct packed {
    logic       start;    // clear captured digits
    logic       wr_time;  // write time digit
    logic       wr_date;  // write date digit
    logic [2:0] pos;      // digit position 0..5
    logic [3:0] digit;    // digit value or NOT_DIGIT
    logic       commit;   // checksum matched, update held values
  } store_ctrl_t;

  // Expected header character at a position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_G;
      3'd1:    c = CH_N;
      3'd2:    c = CH_R;
      3'd3:    c = CH_M;
      3'd4:    c = CH_C;
      default: c = CH_DOLLAR;  // never matches inside a header
    endcase
    return c;
  endfunction

  // Decimal digit or NOT_DIGIT
  function automatic logic [3:0] dec_digit(input logic [7:0] c);
    logic [3:0] d;
    if (c >= 8'h30 && c <= 8'h39) d = c[3:0];
    else d = NOT_DIGIT;
    return d;
  endfunction

  // Hex digit; bit 4 set marks a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    else v = 5'h10;
    return v;
  endfunction

  // Two-digit decimal pair, strtol style
  function automatic logic [6:0] dec_pair(input logic [3:0] a, input logic [3:0] b);
    logic [6:0] v;
    if (a > 4'd9) v = 7'd0;
    else if (b > 4'd9) v = {3'b000, a};
    else v = {a, 3'b000} - {3'b000, a} + {3'b000, a} + {2'b00, a, 1'b0}
             + {3'b000, b};
    return v;
  endfunction

endpackage

// File: rtl/core/nrmc_td_store.sv
// ----------------------------------------------------------------------------
// NMEA RMC time/date digit store
// Captures hhmmss and ddmmyy digits and holds the last valid time and date.
// ----------------------------------------------------------------------------
module nrmc_td_store
  import nrmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  store_ctrl_t ctrl,
  output td_vec_t     held_next
);

  logic [3:0] time_dig [6];
  logic [3:0] date_dig [6];
  td_vec_t    held;
  td_vec_t    decoded;

  // Pair decode of the captured digits
  always_comb begin
    decoded[0] = dec_pair(time_dig[0], time_dig[1]);
    decoded[1] = dec_pair(time_dig[2], time_dig[3]);
    decoded[2] = dec_pair(time_dig[4], time_dig[5]);
    decoded[3] = dec_pair(date_dig[0], date_dig[1]);
    decoded[4] = dec_pair(date_dig[2], date_dig[3]);
    decoded[5] = dec_pair(date_dig[4], date_dig[5]);
    held_next  = (en && ctrl.commit) ? decoded : held;
  end

  // Digit capture and held values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        time_dig[i] <= NOT_DIGIT;
        date_dig[i] <= NOT_DIGIT;
      end
      held <= '0;
    end else if (en) begin
      if (ctrl.start) begin
        for (int i = 0; i < 6; i++) begin
          time_dig[i] <= NOT_DIGIT;
          date_dig[i] <= NOT_DIGIT;
        end
      end else if (ctrl.wr_time) begin
        time_dig[ctrl.pos] <= ctrl.digit;
      end else if (ctrl.wr_date) begin
        date_dig[ctrl.pos] <= ctrl.digit;
      end
      held <= held_next;
    end
  end

endmodule

// File: rtl/core/nmea_rmc_time_date_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC time/date parser
// Watches a byte stream for $GNRMC sentences, checks the XOR checksum and
// keeps the time and date of the last sentence whose checksum matched.
// ----------------------------------------------------------------------------
// An accepted byte is held in the input register; its result is registered
// on the output port when that byte advances through the parse state.
// Throughput: one byte per cycle; the input register and the parse state
// update in a single pass, and a stalled result blocks only bytes that end
// a sentence. Reset clears the parse state to idle and the held time and
// date to zero; no result is pending after reset.
module nmea_rmc_time_date_parser
  import nrmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       checksum_ok,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  output logic [6:0] hours,
  output logic [6:0] minutes,
  output logic [6:0] seconds,
  output logic [6:0] day_of_month,
  output logic [6:0] month_number,
  output logic [6:0] year_two_digit
);

  // Input register
  logic       in_v;
  logic [7:0] in_byte;
  logic       in_last;

  // Parse state
  phase_t     phase, phase_next;
  logic [2:0] hdr_pos, hdr_pos_next;
  logic [7:0] run_xor, run_xor_next;
  logic [3:0] field_num, field_num_next;
  logic [2:0] char_pos, char_pos_next;
  logic [4:0] sum_hi, sum_hi_next;

  // Per-byte decode
  logic        emit;
  logic        advance;
  logic [4:0]  sum_lo;
  logic [7:0]  rx_sum;
  store_ctrl_t ctrl;
  td_vec_t     held_next;

  assign advance  = in_v && (!emit || !out_valid || !out_stall);
  assign in_stall = in_v && !advance;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
      in_last <= buffer_end;
    end
  end

  // Next-state logic
  always_comb begin
    phase_next     = phase;
    hdr_pos_next   = hdr_pos;
    run_xor_next   = run_xor;
    field_num_next = field_num;
    char_pos_next  = char_pos;
    sum_hi_next    = sum_hi;
    if (in_byte == CH_DOLLAR) begin
      phase_next     = PH_HEADER;
      hdr_pos_next   = '0;
      run_xor_next   = '0;
      field_num_next = '0;
      char_pos_next  = '0;
      sum_hi_next    = '0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_pos < HDR_LEN && in_byte == hdr_char(hdr_pos)) begin
            run_xor_next = run_xor ^ in_byte;
            hdr_pos_next = hdr_pos + 3'd1;
            if (hdr_pos == HDR_LEN - 3'd1) phase_next = PH_BODY;
          end else begin
            phase_next     = PH_IDLE;
            hdr_pos_next   = '0;
            field_num_next = '0;
            char_pos_next  = '0;
          end
        end
        PH_BODY: begin
          if (in_byte == CH_STAR) begin
            phase_next = PH_SUM1;
          end else begin
            run_xor_next = run_xor ^ in_byte;
            if (in_byte == CH_COMMA) begin
              if (field_num != FIELD_MAX) field_num_next = field_num + 4'd1;
              char_pos_next = '0;
            end else if (char_pos != POS_MAX) begin
              char_pos_next = char_pos + 3'd1;
            end
          end
        end
        PH_SUM1: begin
          sum_hi_next = hex_value(in_byte);
          phase_next  = PH_SUM2;
        end
        default: begin
          // idle, end of checksum and unused codes
          phase_next     = PH_IDLE;
          hdr_pos_next   = '0;
          field_num_next = '0;
          char_pos_next  = '0;
        end
      endcase
    end
    // partial sentence dropped at end of buffer
    if (in_last && phase_next != PH_IDLE) begin
      phase_next     = PH_IDLE;
      hdr_pos_next   = '0;
      field_num_next = '0;
      char_pos_next  = '0;
    end
  end

  // Output logic: result, digit capture, checksum
  always_comb begin
    sum_lo = hex_value(in_byte);
    priority if (sum_hi[4]) rx_sum = '0;
    else if (sum_lo[4])     rx_sum = {4'h0, sum_hi[3:0]};
    else                    rx_sum = {sum_hi[3:0], sum_lo[3:0]};

    emit         = (in_byte != CH_DOLLAR) && (phase == PH_SUM2);
    ctrl.start   = (in_byte == CH_DOLLAR);
    ctrl.pos     = char_pos;
    ctrl.digit   = dec_digit(in_byte);
    ctrl.wr_time = 1'b0;
    ctrl.wr_date = 1'b0;
    if (!ctrl.start && phase == PH_BODY && in_byte != CH_STAR
        && in_byte != CH_COMMA && char_pos < CAPTURE_LEN) begin
      ctrl.wr_time = (field_num == FIELD_TIME);
      ctrl.wr_date = (field_num == FIELD_DATE);
    end
    ctrl.commit = emit && (rx_sum == run_xor);
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hdr_pos   <= '0;
      run_xor   <= '0;
      field_num <= '0;
      char_pos  <= '0;
      sum_hi    <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      hdr_pos   <= hdr_pos_next;
      run_xor   <= run_xor_next;
      field_num <= field_num_next;
      char_pos  <= char_pos_next;
      sum_hi    <= sum_hi_next;
    end
  end

  nrmc_td_store u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .ctrl      (ctrl),
    .held_next (held_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      checksum_ok    <= ctrl.commit;
      computed_sum   <= run_xor;
      received_sum   <= rx_sum;
      hours          <= held_next[0];
      minutes        <= held_next[1];
      seconds        <= held_next[2];
      day_of_month   <= held_next[3];
      month_number   <= held_next[4];
      year_two_digit <= held_next[5];
    end
  end

`ifndef SYNTHESIS
  // A result transaction only comes from the second checksum character
  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    advance && emit |-> phase == PH_SUM2)
    else $error("result emitted outside checksum phase");

  // The reported flag agrees with the reported sums
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> checksum_ok == (computed_sum == received_sum))
    else $error("checksum flag disagrees with sums");

  // Header position stays inside the header text
  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> hdr_pos < HDR_LEN)
    else $error("header position out of range");

  // A held byte is kept until it is processed
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_v && !advance |=> in_v && $stable(in_byte))
    else $error("buffered byte lost");

  // Parser is idle after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> phase == PH_IDLE && !out_valid && !in_v)
    else $error("parser not idle after reset");
`endif

endmodule

// File: tb/nmea_rmc_time_date_parser_tb.sv
// ----------------------------------------------------------------------------
// NMEA RMC time/date parser testbench
// Streams $GNRMC sentences, broken sentences and line noise into the parser.
// A built-in tracker follows the byte stream and predicts every result: the
// checksum verdict, both sums and the held time and date. Results are
// checked field by field in order.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_parser_tb;
  import nrmc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYC   = 20;
  localparam int RAND_BYTES   = 950;
  localparam int PAUSE_EVERY  = 350;
  localparam int MAX_PRINTS   = 100;

  localparam logic [7:0] HDR_TEXT [5] = '{CH_G, CH_N, CH_R, CH_M, CH_C};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } rx_item_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] calc_sum;
    logic [7:0] rx_sum;
    td_vec_t    td;  // hour, minute, second, day, month, year
  } fix_t;

  // How the two characters after '*' are formed
  typedef enum int {
    SUM_GOOD,
    SUM_GOOD_LC,
    SUM_BAD,
    SUM_JUNK,
    SUM_HALF
  } sum_mode_t;

  // Clock, reset and DUT ports
  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte    = '0;
  logic       buffer_end = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       checksum_ok;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic [6:0] hours;
  logic [6:0] minutes;
  logic [6:0] seconds;
  logic [6:0] day_of_month;
  logic [6:0] month_number;
  logic [6:0] year_two_digit;

  always #CLK_HALF clk = ~clk;

  nmea_rmc_time_date_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .buffer_end     (buffer_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .checksum_ok    (checksum_ok),
    .computed_sum   (computed_sum),
    .received_sum   (received_sum),
    .hours          (hours),
    .minutes        (minutes),
    .seconds        (seconds),
    .day_of_month   (day_of_month),
    .month_number   (month_number),
    .year_two_digit (year_two_digit)
  );

  // Bookkeeping
  rx_item_t   rx_pending_q[$];
  fix_t       expected_fix_q[$];
  int         err_count   = 0;
  int         cycle_count = 0;
  bit         in_took     = 1'b0;
  int         send_gap_pct = 25;
  int         stall_pct    = 25;

  // Sentence tracker state
  phase_t     trk_phase   = PH_IDLE;
  logic [2:0] trk_hdr_pos = '0;
  logic [7:0] trk_xor     = '0;
  logic [3:0] trk_field   = '0;
  logic [2:0] trk_char    = '0;
  logic [3:0] trk_time [6] = '{default: NOT_DIGIT};
  logic [3:0] trk_date [6] = '{default: NOT_DIGIT};
  logic [4:0] trk_sum_hi  = '0;
  td_vec_t    trk_held    = '0;

  // --------------------------------------------------------------------------
  // Tracker helpers
  // --------------------------------------------------------------------------

  // Hex value of a character; bit 4 flags a non-hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'h10;
  endfunction

  // Two captured digits read strtol style
  function automatic logic [6:0] digit_pair(input logic [3:0] a, input logic [3:0] b);
    if (a > 4'd9) return 7'd0;
    if (b > 4'd9) return 7'(a);
    return 7'(a * 10 + b);
  endfunction

  task automatic to_idle();
    trk_phase   = PH_IDLE;
    trk_hdr_pos = '0;
    trk_field   = '0;
    trk_char    = '0;
  endtask

  // Follow one accepted byte; queue a result when a sentence completes
  task automatic rmc_track_byte(input logic [7:0] b, input logic last);
    logic [4:0] lo;
    logic [7:0] rx;
    logic [3:0] d;
    fix_t       f;
    if (b == CH_DOLLAR) begin
      trk_phase   = PH_HEADER;
      trk_hdr_pos = '0;
      trk_xor     = '0;
      trk_field   = '0;
      trk_char    = '0;
      trk_sum_hi  = '0;
      for (int i = 0; i < 6; i++) begin
        trk_time[i] = NOT_DIGIT;
        trk_date[i] = NOT_DIGIT;
      end
    end else begin
      case (trk_phase)
        PH_HEADER: begin
          if (trk_hdr_pos < HDR_LEN && b == HDR_TEXT[trk_hdr_pos]) begin
            trk_xor ^= b;
            trk_hdr_pos++;
            if (trk_hdr_pos == HDR_LEN) trk_phase = PH_BODY;
          end else begin
            to_idle();
          end
        end
        PH_BODY: begin
          if (b == CH_STAR) begin
            trk_phase = PH_SUM1;
          end else begin
            trk_xor ^= b;
            if (b == CH_COMMA) begin
              if (trk_field < FIELD_MAX) trk_field++;
              trk_char = '0;
            end else begin
              if (trk_char < CAPTURE_LEN) begin
                d = (b >= "0" && b <= "9") ? 4'(b - "0") : NOT_DIGIT;
                if (trk_field == FIELD_TIME) trk_time[trk_char] = d;
                else if (trk_field == FIELD_DATE) trk_date[trk_char] = d;
              end
              if (trk_char < POS_MAX) trk_char++;
            end
          end
        end
        PH_SUM1: begin
          trk_sum_hi = hex_nibble(b);
          trk_phase  = PH_SUM2;
        end
        PH_SUM2: begin
          lo = hex_nibble(b);
          if (trk_sum_hi[4]) rx = 8'h00;
          else if (lo[4]) rx = {4'h0, trk_sum_hi[3:0]};
          else rx = {trk_sum_hi[3:0], lo[3:0]};
          f.ok = (rx == trk_xor);
          if (f.ok) begin
            for (int k = 0; k < 3; k++) begin
              trk_held[k]     = digit_pair(trk_time[2*k], trk_time[2*k+1]);
              trk_held[k + 3] = digit_pair(trk_date[2*k], trk_date[2*k+1]);
            end
          end
          f.calc_sum = trk_xor;
          f.rx_sum   = rx;
          f.td       = trk_held;
          expected_fix_q.push_back(f);
          to_idle();
        end
        default: to_idle();
      endcase
    end
    // end of buffer drops whatever is still open
    if (last && trk_phase != PH_IDLE) to_idle();
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_fix();
    fix_t want;
    if (expected_fix_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected (sums %02h/%02h)",
                                computed_sum, received_sum));
    end else begin
      want = expected_fix_q.pop_front();
      check_field("checksum_ok", {7'b0, checksum_ok}, {7'b0, want.ok});
      check_field("computed_sum", computed_sum, want.calc_sum);
      check_field("received_sum", received_sum, want.rx_sum);
      check_field("hours", {1'b0, hours}, {1'b0, want.td[0]});
      check_field("minutes", {1'b0, minutes}, {1'b0, want.td[1]});
      check_field("seconds", {1'b0, seconds}, {1'b0, want.td[2]});
      check_field("day_of_month", {1'b0, day_of_month}, {1'b0, want.td[3]});
      check_field("month_number", {1'b0, month_number}, {1'b0, want.td[4]});
      check_field("year_two_digit", {1'b0, year_two_digit}, {1'b0, want.td[5]});
    end
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    in_took = 1'b0;
    if (!rst) begin
      cycle_count++;
      if (out_valid && !out_stall) check_fix();
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        rmc_track_byte(rx_byte, buffer_end);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver and receiver, both acting on the falling edge
  // --------------------------------------------------------------------------

  function automatic bit pct(input int p);
    return $urandom_range(0, 99) < p;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if (pct(88)) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int send_gap = 0;

  always @(negedge clk) begin : byte_driver
    rx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled transaction is held as is
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (rx_pending_q.size() > 0) begin
      it = rx_pending_q.pop_front();
      rx_byte    <= it.ch;
      buffer_end <= it.last;
      in_valid   <= 1'b1;
      if (pct(send_gap_pct)) send_gap = gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  int stall_left = 0;

  always @(negedge clk) begin : result_stall
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (pct(stall_pct)) stall_left = gap_len();
    end
  end

  // --------------------------------------------------------------------------
  // Sentence builder
  // --------------------------------------------------------------------------

  logic [7:0] snt[$];         // text between '$' and '*'
  int         body_bytes = 0;  // sentence bytes queued, noise not counted

  task automatic push_item(input logic [7:0] ch, input logic last);
    rx_item_t it;
    it.ch   = ch;
    it.last = last;
    rx_pending_q.push_back(it);
  endtask

  function automatic logic [7:0] snt_xor();
    logic [7:0] acc;
    acc = '0;
    foreach (snt[i]) acc ^= snt[i];
    return acc;
  endfunction

  // Anything that keeps a sentence open: not '$' and not '*'
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR || c == CH_STAR);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = body_char(); while (hex_nibble(c) < 5'h10);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lc);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lc ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) snt.push_back(s[i]);
  endtask

  task automatic put_field(input int n, input int noise_pct);
    repeat (n) begin
      if (pct(noise_pct)) snt.push_back(body_char());
      else snt.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end
  endtask

  // Time or date stamp: usually six digits, sometimes of random length or dirty
  task automatic put_stamp(input bit frac);
    if (pct(85)) begin
      put_field(6, 0);
      if (frac && pct(70)) begin
        snt.push_back(".");
        put_field(2, 0);
      end
    end else begin
      put_field($urandom_range(0, 9), 30);
    end
  endtask

  task automatic build_rmc();
    snt.delete();
    put_text("GNRMC,");
    put_stamp(1'b1);
    for (int f = 2; f <= 8; f++) begin
      snt.push_back(CH_COMMA);
      put_field($urandom_range(0, 4), 40);
    end
    snt.push_back(CH_COMMA);
    put_stamp(1'b0);
    repeat (pct(85) ? 3 : $urandom_range(0, 10)) begin
      snt.push_back(CH_COMMA);
      put_field($urandom_range(0, 2), 50);
    end
  endtask

  // Append a field that brings the running XOR to a chosen value
  task automatic force_sum(input logic [7:0] target);
    logic [7:0] fix;
    snt.push_back(CH_COMMA);
    fix = snt_xor() ^ target;
    while (fix == CH_DOLLAR || fix == CH_STAR) begin
      snt.push_back(body_char());
      fix = snt_xor() ^ target;
    end
    snt.push_back(fix);
  endtask

  // Frame the sentence and queue it; drop trims bytes off the tail,
  // end_back puts buffer_end that many bytes before the last one sent
  task automatic send_snt(input sum_mode_t mode, input int drop = 0, input int end_back = -1);
    logic [7:0] frame[$];
    logic [7:0] s;
    int         n;
    bit         lc;
    s  = snt_xor();
    lc = pct(50);
    frame.push_back(CH_DOLLAR);
    foreach (snt[i]) frame.push_back(snt[i]);
    frame.push_back(CH_STAR);
    case (mode)
      SUM_GOOD: begin
        frame.push_back(hex_char(s[7:4], 1'b0));
        frame.push_back(hex_char(s[3:0], 1'b0));
      end
      SUM_GOOD_LC: begin
        frame.push_back(hex_char(s[7:4], 1'b1));
        frame.push_back(hex_char(s[3:0], 1'b1));
      end
      SUM_BAD: begin
        s ^= 8'($urandom_range(1, 255));
        frame.push_back(hex_char(s[7:4], lc));
        frame.push_back(hex_char(s[3:0], lc));
      end
      SUM_JUNK: begin
        frame.push_back(non_hex_char());
        frame.push_back(body_char());
      end
      default: begin
        frame.push_back(hex_char(s[3:0], lc));
        frame.push_back(non_hex_char());
      end
    endcase
    n = frame.size() - drop;
    if (n < 0) n = 0;
    for (int i = 0; i < n; i++) push_item(frame[i], i == n - 1 - end_back);
    body_bytes += n;
  endtask

  task automatic noise(input int n);
    repeat (n) push_item(8'($urandom_range(0, 255)), pct(10));
  endtask

  function automatic sum_mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return SUM_GOOD;
    if (r < 72) return SUM_GOOD_LC;
    if (r < 85) return SUM_BAD;
    if (r < 93) return SUM_JUNK;
    return SUM_HALF;
  endfunction

  // Hold the sender until every queued byte is in and every result is out
  task automatic drain();
    while (rx_pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_fix_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    int next_pause;
    int chunk;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: extremes, digit pair rules, framing corner cases
    noise(4);
    snt.delete(); put_text("GNRMC,999999.99,A,,,,,,,999999,,,A"); send_snt(SUM_GOOD);
    snt.delete(); put_text("GNRMC,000000,A,,,,,,,000000,,,A"); send_snt(SUM_GOOD_LC);
    // wrong sum leaves held values alone
    snt.delete(); put_text("GNRMC,123456,A,,,,,,,010203"); send_snt(SUM_BAD);
    // short fields and non-digit characters
    snt.delete(); put_text("GNRMC,1,A,,,,,,,12"); send_snt(SUM_GOOD);
    snt.delete(); put_text("GNRMC,a55b9,,,,,,,,1x2y3z"); send_snt(SUM_GOOD);
    // over-long fields and a saturating field counter
    snt.delete(); put_text("GNRMC,12345678,,,,,,,,87654321,,,,,,,,,,,,"); send_snt(SUM_GOOD);
    // bare header with no fields
    snt.delete(); put_text("GNRMC"); send_snt(SUM_GOOD);
    // header mismatch gives no result
    snt.delete(); put_text("GNRMX,101010,,,,,,,,101010"); send_snt(SUM_GOOD);
    // new '$' mid-body, then during the checksum
    snt.delete(); put_text("GNRMC,202020,,,,,,,,202020"); send_snt(SUM_GOOD, 12);
    snt.delete(); put_text("GNRMC,212121,,,,,,,,212121"); send_snt(SUM_GOOD, 1);
    snt.delete(); put_text("GNRMC,222222,,,,,,,,222222"); send_snt(SUM_GOOD);
    // buffer end inside a sentence drops it; on the last byte it does not
    snt.delete(); put_text("GNRMC,232323,,,,,,,,232323"); send_snt(SUM_GOOD, 0, 10);
    snt.delete(); put_text("GNRMC,242424,,,,,,,,242424"); send_snt(SUM_GOOD, 0, 0);
    // non-hex first sum character reads as zero, non-hex second keeps the first
    snt.delete(); put_text("GNRMC,101112,,,,,,,,131415"); force_sum(8'h00); send_snt(SUM_JUNK);
    snt.delete(); put_text("GNRMC,050607,,,,,,,,080910"); force_sum(8'h0B); send_snt(SUM_HALF);
    drain();

    // Random: mostly well-formed sentences with random content
    body_bytes = 0;
    next_pause = PAUSE_EVERY;
    chunk = 0;
    while (body_bytes < RAND_BYTES) begin
      r = $urandom_range(0, 99);
      build_rmc();
      if (r < 70) begin
        send_snt(pick_mode(), 0, pct(10) ? 0 : -1);
      end else if (r < 78) begin
        snt[$urandom_range(0, 4)] = body_char();
        send_snt(pick_mode());
      end else if (r < 86) begin
        send_snt(pick_mode(), $urandom_range(1, snt.size() + 3));
      end else if (r < 92) begin
        send_snt(pick_mode(), 0, $urandom_range(1, snt.size() + 3));
      end else begin
        noise($urandom_range(1, 8));
      end
      // periodic full pause, and a change of traffic pattern
      if (body_bytes >= next_pause) begin
        drain();
        next_pause += PAUSE_EVERY;
        chunk++;
        case (chunk % 3)
          0: begin send_gap_pct = 25; stall_pct = 25; end
          1: begin send_gap_pct = 0;  stall_pct = 0;  end
          default: begin send_gap_pct = 10; stall_pct = 50; end
        endcase
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
